// ===== hw/rtl/tksd_pkg.sv =====
// Package for the terminal key sequence decoder.
// Holds the decoder state and key event types, key codes and byte constants.
// No dependencies.
package tksd_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ESC  = 2'd1,
        PH_CSI  = 2'd2,
        PH_SS3  = 2'd3
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] first_param;
        logic [31:0] second_param;
        logic [2:0]  param_count;
    } t_state;

    typedef struct packed {
        logic [4:0]  key_special;
        logic [31:0] char_code;
        logic [2:0]  modifiers;
    } t_key;

    localparam logic [4:0] K_CHAR   = 5'd0;
    localparam logic [4:0] K_ESC    = 5'd1;
    localparam logic [4:0] K_UP     = 5'd2;
    localparam logic [4:0] K_DOWN   = 5'd3;
    localparam logic [4:0] K_RIGHT  = 5'd4;
    localparam logic [4:0] K_LEFT   = 5'd5;
    localparam logic [4:0] K_HOME   = 5'd6;
    localparam logic [4:0] K_END    = 5'd7;
    localparam logic [4:0] K_INS    = 5'd8;
    localparam logic [4:0] K_DEL    = 5'd9;
    localparam logic [4:0] K_PGUP   = 5'd10;
    localparam logic [4:0] K_PGDN   = 5'd11;
    localparam logic [4:0] K_F1     = 5'd12;
    localparam logic [4:0] K_F5     = 5'd16;
    localparam logic [4:0] K_F6     = 5'd17;
    localparam logic [4:0] K_F7     = 5'd18;
    localparam logic [4:0] K_F8     = 5'd19;
    localparam logic [4:0] K_F9     = 5'd20;
    localparam logic [4:0] K_F10    = 5'd21;
    localparam logic [4:0] K_F11    = 5'd22;
    localparam logic [4:0] K_F12    = 5'd23;
    localparam logic [4:0] K_LAST   = 5'd23;

    localparam logic [2:0] MOD_NONE  = 3'b000;
    localparam logic [2:0] MOD_ALT   = 3'b010;
    localparam logic [2:0] MOD_CTRL  = 3'b100;

    localparam logic [7:0] B_ESC       = 8'h1B;
    localparam logic [7:0] B_CTRL_LAST = 8'd26;
    localparam logic [7:0] B_BS        = 8'h08;
    localparam logic [7:0] B_TAB       = 8'h09;
    localparam logic [7:0] B_LF        = 8'h0A;
    localparam logic [7:0] B_CR        = 8'h0D;
    localparam logic [7:0] B_LETTER0   = 8'h60;
    localparam logic [7:0] B_FINAL_LO  = 8'h40;
    localparam logic [7:0] B_FINAL_HI  = 8'h7E;

    localparam logic [2:0] PARAM_MAX   = 3'd4;
    localparam logic [31:0] CP_ESC     = 32'h0000_001B;

    function automatic logic [4:0] tilde_key(input logic [31:0] v);
        logic [4:0] k;
        begin
            case (v)
                32'd2:   k = K_INS;
                32'd3:   k = K_DEL;
                32'd5:   k = K_PGUP;
                32'd6:   k = K_PGDN;
                32'd15:  k = K_F5;
                32'd17:  k = K_F6;
                32'd18:  k = K_F7;
                32'd19:  k = K_F8;
                32'd20:  k = K_F9;
                32'd21:  k = K_F10;
                32'd23:  k = K_F11;
                32'd24:  k = K_F12;
                default: k = K_CHAR;
            endcase
            return k;
        end
    endfunction

endpackage

// ===== hw/rtl/tksd_if.sv =====
// Stream interfaces for the terminal key sequence decoder.
// Depends on nothing; payload widths are fixed by the byte and key formats.
interface tksd_byte_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;

    modport source(output valid, output func, output data_byte, input ready);
    modport sink(input valid, input func, input data_byte, output ready);
endinterface

interface tksd_key_if;
    logic        valid;
    logic        ready;
    logic [4:0]  key_special;
    logic [31:0] char_code;
    logic [2:0]  modifiers;

    modport source(output valid, output key_special, output char_code,
                   output modifiers, input ready);
    modport sink(input valid, input key_special, input char_code,
                 input modifiers, output ready);
endinterface

// ===== hw/rtl/tksd_step.sv =====
// Next-state and key event logic for one byte or timeout request.
// Depends on tksd_pkg.
module tksd_step (
    input  tksd_pkg::t_state i_state,
    input  logic             i_func,
    input  logic [7:0]       i_byte,
    output tksd_pkg::t_state o_state,
    output logic             o_emit,
    output tksd_pkg::t_key   o_key
);
    import tksd_pkg::*;

    logic        is_ctrl;
    logic        is_digit;
    logic [31:0] digit;
    logic [2:0]  pc_open;
    logic [31:0] mod_src;
    logic [2:0]  csi_mods;
    logic [31:0] letter;

    always_comb begin
        is_ctrl  = (i_byte >= 8'd1) && (i_byte <= B_CTRL_LAST);
        is_digit = (i_byte >= "0") && (i_byte <= "9");
        digit    = {28'd0, i_byte[3:0]};
        pc_open  = (i_state.param_count == 3'd0) ? 3'd1 : i_state.param_count;
        mod_src  = (i_state.param_count > 3'd1) ? i_state.second_param : 32'd0;
        csi_mods = (mod_src == 32'd0) ? MOD_NONE : (mod_src[2:0] - 3'd1);
        letter   = {24'd0, B_LETTER0 + i_byte};
    end

    always_comb begin
        o_state = i_state;
        o_emit  = 1'b0;
        o_key   = '{key_special: K_CHAR, char_code: 32'd0, modifiers: MOD_NONE};
        if (i_func) begin
            if (i_state.phase == PH_ESC) begin
                o_state.phase     = PH_IDLE;
                o_emit            = 1'b1;
                o_key.key_special = K_ESC;
            end
        end else begin
            case (i_state.phase)
                PH_IDLE: begin
                    if (i_byte == B_ESC) begin
                        o_state.phase = PH_ESC;
                    end else begin
                        o_emit = 1'b1;
                        if (is_ctrl && i_byte != B_BS && i_byte != B_TAB &&
                            i_byte != B_LF && i_byte != B_CR) begin
                            o_key.char_code = letter;
                            o_key.modifiers = MOD_CTRL;
                        end else begin
                            o_key.char_code = {24'd0, i_byte};
                        end
                    end
                end
                PH_ESC: begin
                    if (i_byte == "[") begin
                        o_state.phase        = PH_CSI;
                        o_state.first_param  = 32'd0;
                        o_state.second_param = 32'd0;
                        o_state.param_count  = 3'd0;
                    end else if (i_byte == "O") begin
                        o_state.phase = PH_SS3;
                    end else begin
                        o_state.phase = PH_IDLE;
                        o_emit        = 1'b1;
                        if (is_ctrl) begin
                            o_key.char_code = letter;
                            o_key.modifiers = MOD_ALT | MOD_CTRL;
                        end else begin
                            o_key.char_code = {24'd0, i_byte};
                            o_key.modifiers = MOD_ALT;
                        end
                    end
                end
                PH_SS3: begin
                    o_state.phase = PH_IDLE;
                    if (i_byte >= "P" && i_byte <= "S") begin
                        o_emit            = 1'b1;
                        o_key.key_special = K_F1 + {3'd0, i_byte[1:0]};
                    end
                end
                PH_CSI: begin
                    if (is_digit) begin
                        o_state.param_count = pc_open;
                        if (pc_open == 3'd1) begin
                            o_state.first_param = {i_state.first_param[28:0], 3'd0}
                                + {i_state.first_param[30:0], 1'b0} + digit;
                        end else if (pc_open == 3'd2) begin
                            o_state.second_param = {i_state.second_param[28:0], 3'd0}
                                + {i_state.second_param[30:0], 1'b0} + digit;
                        end
                    end else if (i_byte == ";") begin
                        o_state.param_count = (pc_open < PARAM_MAX) ? pc_open + 3'd1
                                                                    : pc_open;
                    end else if (i_byte >= B_FINAL_LO && i_byte <= B_FINAL_HI) begin
                        o_state.phase        = PH_IDLE;
                        o_state.first_param  = 32'd0;
                        o_state.second_param = 32'd0;
                        o_state.param_count  = 3'd0;
                        o_key.modifiers      = csi_mods;
                        o_emit               = 1'b1;
                        case (i_byte)
                            "A": o_key.key_special = K_UP;
                            "B": o_key.key_special = K_DOWN;
                            "C": o_key.key_special = K_RIGHT;
                            "D": o_key.key_special = K_LEFT;
                            "H": o_key.key_special = K_HOME;
                            "F": o_key.key_special = K_END;
                            "P", "Q", "R", "S": begin
                                o_key.key_special = K_F1 + {3'd0, i_byte[1:0]};
                            end
                            "~": begin
                                o_key.key_special = tilde_key(i_state.first_param);
                                o_emit = (o_key.key_special != K_CHAR);
                            end
                            "u": begin
                                if (i_state.first_param == CP_ESC) begin
                                    o_key.key_special = K_ESC;
                                end else begin
                                    o_key.char_code = i_state.first_param;
                                end
                            end
                            default: o_emit = 1'b0;
                        endcase
                    end
                end
                default: o_state.phase = PH_IDLE;
            endcase
        end
    end

endmodule

// ===== hw/rtl/terminal_key_sequence_decoder.sv =====
// Top level of the terminal key sequence decoder.
// Depends on tksd_pkg, the interfaces in tksd_if and the tksd_step module.
//
// The request channel i_req carries one terminal byte (func low) or one
// read-timeout tick (func high) per request. The key channel o_key carries
// key events: a special-key number, a character code and modifier bits.
// A request causes zero or one key event; escape prefixes, SS3 and CSI
// bytes are absorbed until the sequence completes.
// A request is taken into an input register, decoded from there against the
// sequence state, and its key event is then registered in the result register.
// One request is accepted every cycle while the input register is not held by
// a stall; the only per-request work is one pass through the decoder between
// the input and result registers.
// When the receiver holds o_key.ready low, the result register holds its
// event and the input register holds the next request, so at most two
// requests that cause events are taken before i_req.ready drops. A request
// that causes no event is still decoded during a stall.
// Reset empties both registers, returns to the idle state and clears the
// CSI parameters.
module terminal_key_sequence_decoder (
    input  logic i_clk,
    input  logic i_rst_n,
    tksd_byte_if.sink  i_req,
    tksd_key_if.source o_key
);
    import tksd_pkg::*;

    logic       r_in_valid;
    logic       r_func;
    logic [7:0] r_byte;
    t_state     r_state;
    t_state     n_state;
    logic       r_out_valid;
    t_key       r_key;
    t_key       n_key;
    logic       n_emit;
    logic       in_ready;
    logic       fire;

    tksd_step u_step (
        .i_state (r_state),
        .i_func  (r_func),
        .i_byte  (r_byte),
        .o_state (n_state),
        .o_emit  (n_emit),
        .o_key   (n_key)
    );

    always_comb begin
        fire     = r_in_valid && (!n_emit || !r_out_valid || o_key.ready);
        in_ready = !r_in_valid || fire;
    end

    assign i_req.ready       = in_ready;
    assign o_key.valid       = r_out_valid;
    assign o_key.key_special = r_key.key_special;
    assign o_key.char_code   = r_key.char_code;
    assign o_key.modifiers   = r_key.modifiers;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_state <= '{phase: PH_IDLE, first_param: 32'd0,
                         second_param: 32'd0, param_count: 3'd0};
        end else begin
            if (in_ready) begin
                r_in_valid <= i_req.valid;
            end
            if (fire) begin
                r_state <= n_state;
            end
            if (fire && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_key.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_req.valid) begin
            r_func <= i_req.func;
            r_byte <= i_req.data_byte;
        end
        if (fire && n_emit) begin
            r_key <= n_key;
        end
    end

    a_param_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.param_count <= PARAM_MAX)
        else $error("CSI parameter count out of range.");

    a_params_clear_outside_csi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase != PH_CSI |-> (r_state.first_param == 32'd0 &&
            r_state.second_param == 32'd0 && r_state.param_count == 3'd0))
        else $error("CSI parameters not cleared outside a CSI sequence.");

    a_key_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_key.key_special <= K_LAST &&
            (r_key.key_special == K_CHAR || r_key.char_code == 32'd0)))
        else $error("Key event has an invalid special key or code.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_key.ready) |=> (r_out_valid && $stable(r_key)))
        else $error("Pending key event was lost.");

endmodule

// ===== bench/tb_terminal_key_sequence_decoder.sv =====
`timescale 1ns / 1ps
// Self-checking bench for terminal_key_sequence_decoder: byte and timeout requests in, key events out.
// Depends on tksd_pkg and the stream interfaces in tksd_if; expected key events come from a local decoder.
module tb_terminal_key_sequence_decoder;
    import tksd_pkg::*;

    localparam logic       FUNC_BYTE    = 1'b0;
    localparam logic       FUNC_TIMEOUT = 1'b1;
    localparam logic [7:0] B_CTRL_FIRST = 8'h01;
    localparam logic [7:0] B_SS3        = 8'h4F;
    localparam logic [7:0] B_CSI        = 8'h5B;
    localparam logic [7:0] B_SEMI       = 8'h3B;
    localparam logic [7:0] B_DIGIT0     = 8'h30;
    localparam logic [7:0] B_DIGIT9     = 8'h39;
    localparam logic [7:0] B_FIN_UP     = 8'h41;
    localparam logic [7:0] B_FIN_DOWN   = 8'h42;
    localparam logic [7:0] B_FIN_RIGHT  = 8'h43;
    localparam logic [7:0] B_FIN_LEFT   = 8'h44;
    localparam logic [7:0] B_FIN_END    = 8'h46;
    localparam logic [7:0] B_FIN_HOME   = 8'h48;
    localparam logic [7:0] B_FIN_P      = 8'h50;
    localparam logic [7:0] B_FIN_S      = 8'h53;
    localparam logic [7:0] B_FIN_U      = 8'h75;
    localparam logic [7:0] B_TILDE      = 8'h7E;
    localparam int         STIM_ITEMS   = 1650;
    localparam int         PRINT_CAP    = 40;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } t_req;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_RUNS, RX_PERIODIC} t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    tksd_byte_if req_if();
    tksd_key_if  key_if();

    terminal_key_sequence_decoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_key   (key_if)
    );

    t_req pending_reqs[$];
    t_key expected_keys[$];

    t_phase      dec_phase  = PH_IDLE;
    logic [31:0] dec_param1 = '0;
    logic [31:0] dec_param2 = '0;
    logic [2:0]  dec_count  = '0;

    int   stimulus_items = 0;
    int   accepted_reqs  = 0;
    int   timeout_reqs   = 0;
    int   key_events     = 0;
    int   special_keys   = 0;
    int   mismatch_count = 0;
    int   burst_left     = 0;
    int   gap_left       = 0;
    int   stall_left     = 0;
    int   rx_cycle       = 0;
    logic req_fire       = 1'b0;

    int          tilde_params[12] = '{2, 3, 5, 6, 15, 17, 18, 19, 20, 21, 23, 24};
    logic [7:0]  basic_finals[10] = '{B_FIN_UP, B_FIN_DOWN, B_FIN_RIGHT, B_FIN_LEFT,
                                      B_FIN_HOME, B_FIN_END, B_FIN_P, 8'h51, 8'h52, B_FIN_S};

    always #5 i_clk = ~i_clk;

    function automatic logic [5:0] tilde_lookup(input logic [31:0] v);
        case (v)
            32'd2:   return {1'b1, K_INS};
            32'd3:   return {1'b1, K_DEL};
            32'd5:   return {1'b1, K_PGUP};
            32'd6:   return {1'b1, K_PGDN};
            32'd15:  return {1'b1, K_F5};
            32'd17:  return {1'b1, K_F6};
            32'd18:  return {1'b1, K_F7};
            32'd19:  return {1'b1, K_F8};
            32'd20:  return {1'b1, K_F9};
            32'd21:  return {1'b1, K_F10};
            32'd23:  return {1'b1, K_F11};
            32'd24:  return {1'b1, K_F12};
            default: return '0;
        endcase
    endfunction

    task automatic decode_request(input logic tmo, input logic [7:0] b);
        t_key        ev;
        logic        hit;
        logic [2:0]  mods;
        logic [31:0] p0;
        logic [31:0] p2m1;
        logic [5:0]  tk;
        begin
            ev  = '0;
            hit = 1'b0;
            if (tmo) begin
                if (dec_phase == PH_ESC) begin
                    dec_phase      = PH_IDLE;
                    ev.key_special = K_ESC;
                    hit            = 1'b1;
                end
            end else begin
                case (dec_phase)
                    PH_IDLE: begin
                        if (b == B_ESC) begin
                            dec_phase = PH_ESC;
                        end else begin
                            hit          = 1'b1;
                            ev.char_code = {24'd0, b};
                            if (b >= B_CTRL_FIRST && b <= B_CTRL_LAST && b != B_BS &&
                                b != B_TAB && b != B_LF && b != B_CR) begin
                                ev.char_code = {24'd0, B_LETTER0 + b};
                                ev.modifiers = MOD_CTRL;
                            end
                        end
                    end
                    PH_ESC: begin
                        if (b == B_CSI) begin
                            dec_phase  = PH_CSI;
                            dec_param1 = '0;
                            dec_param2 = '0;
                            dec_count  = '0;
                        end else if (b == B_SS3) begin
                            dec_phase = PH_SS3;
                        end else begin
                            dec_phase    = PH_IDLE;
                            hit          = 1'b1;
                            ev.char_code = {24'd0, b};
                            ev.modifiers = MOD_ALT;
                            if (b >= B_CTRL_FIRST && b <= B_CTRL_LAST) begin
                                ev.char_code = {24'd0, B_LETTER0 + b};
                                ev.modifiers = MOD_ALT | MOD_CTRL;
                            end
                        end
                    end
                    PH_SS3: begin
                        dec_phase = PH_IDLE;
                        if (b >= B_FIN_P && b <= B_FIN_S) begin
                            hit            = 1'b1;
                            ev.key_special = K_F1 + 5'(b - B_FIN_P);
                        end
                    end
                    default: begin
                        if (b >= B_DIGIT0 && b <= B_DIGIT9) begin
                            if (dec_count == 3'd0)
                                dec_count = 3'd1;
                            if (dec_count == 3'd1)
                                dec_param1 = dec_param1 * 32'd10 + 32'(b - B_DIGIT0);
                            else if (dec_count == 3'd2)
                                dec_param2 = dec_param2 * 32'd10 + 32'(b - B_DIGIT0);
                        end else if (b == B_SEMI) begin
                            if (dec_count == 3'd0)
                                dec_count = 3'd1;
                            if (dec_count < PARAM_MAX)
                                dec_count = dec_count + 3'd1;
                        end else if (b >= B_FINAL_LO && b <= B_FINAL_HI) begin
                            p2m1 = dec_param2 - 32'd1;
                            mods = (dec_count > 3'd1 && dec_param2 != 0) ? p2m1[2:0] : MOD_NONE;
                            p0   = dec_param1;
                            dec_phase  = PH_IDLE;
                            dec_param1 = '0;
                            dec_param2 = '0;
                            dec_count  = '0;
                            ev.modifiers = mods;
                            hit = 1'b1;
                            if (b == B_TILDE) begin
                                tk = tilde_lookup(p0);
                                hit = tk[5];
                                ev.key_special = tk[4:0];
                            end else if (b == B_FIN_U) begin
                                if (p0 == CP_ESC)
                                    ev.key_special = K_ESC;
                                else
                                    ev.char_code = p0;
                            end else if (b >= B_FIN_P && b <= B_FIN_S) begin
                                ev.key_special = K_F1 + 5'(b - B_FIN_P);
                            end else begin
                                case (b)
                                    B_FIN_UP:    ev.key_special = K_UP;
                                    B_FIN_DOWN:  ev.key_special = K_DOWN;
                                    B_FIN_RIGHT: ev.key_special = K_RIGHT;
                                    B_FIN_LEFT:  ev.key_special = K_LEFT;
                                    B_FIN_HOME:  ev.key_special = K_HOME;
                                    B_FIN_END:   ev.key_special = K_END;
                                    default:     hit = 1'b0;
                                endcase
                            end
                        end
                    end
                endcase
            end
            if (hit)
                expected_keys.push_back(ev);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            mismatch_count++;
            if (mismatch_count <= PRINT_CAP)
                $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                         want);
        end
    endtask

    task automatic queue_req(input logic f, input logic [7:0] b, input bit ignored);
        t_req r;
        begin
            r.func      = f;
            r.data_byte = b;
            pending_reqs.push_back(r);
            if (!ignored)
                stimulus_items++;
        end
    endtask

    task automatic queue_number(input logic [31:0] v);
        logic [7:0]  digs[$];
        logic [31:0] rest;
        begin
            rest = v;
            do begin
                digs.push_front(B_DIGIT0 + 8'(rest % 10));
                rest = rest / 10;
            end while (rest != 0);
            if ($urandom_range(0, 15) == 0)
                digs.push_front(B_DIGIT0);
            foreach (digs[i])
                queue_req(FUNC_BYTE, digs[i], 1'b0);
        end
    endtask

    task automatic queue_stray();
        logic [7:0] b;
        begin
            if ($urandom_range(0, 2) == 0) begin
                queue_req(FUNC_TIMEOUT, 8'($urandom_range(0, 255)), 1'b1);
            end else begin
                do begin
                    b = 8'($urandom_range(0, 255));
                end while ((b >= B_DIGIT0 && b <= B_DIGIT9) || b == B_SEMI ||
                           (b >= B_FINAL_LO && b <= B_FINAL_HI));
                queue_req(FUNC_BYTE, b, 1'b0);
            end
        end
    endtask

    task automatic queue_param(input logic [31:0] v);
        int r;
        int n;
        begin
            r = $urandom_range(0, 11);
            if (r == 1) begin
                n = $urandom_range(10, 20);
                repeat (n) queue_req(FUNC_BYTE, B_DIGIT0 + 8'($urandom_range(0, 9)), 1'b0);
            end else if (r != 0) begin
                queue_number(v);
            end
        end
    endtask

    task automatic queue_csi();
        int          r;
        int          nparams;
        logic [7:0]  fin;
        logic [31:0] v;
        begin
            queue_req(FUNC_BYTE, B_ESC, 1'b0);
            queue_req(FUNC_BYTE, B_CSI, 1'b0);
            r = $urandom_range(0, 9);
            if (r < 4)
                fin = basic_finals[$urandom_range(0, 9)];
            else if (r < 6)
                fin = B_TILDE;
            else if (r < 8)
                fin = B_FIN_U;
            else
                fin = 8'($urandom_range(B_FINAL_LO, B_FINAL_HI));
            r = $urandom_range(0, 9);
            nparams = (r == 0) ? 0 : (r < 4) ? 1 : (r < 8) ? 2 : (r == 8) ? 3 : 4;
            for (int i = 0; i < nparams; i++) begin
                if ($urandom_range(0, 9) == 0)
                    queue_stray();
                if (i > 0)
                    queue_req(FUNC_BYTE, B_SEMI, 1'b0);
                if (i == 0) begin
                    if (fin == B_TILDE) begin
                        v = ($urandom_range(0, 6) != 0) ? tilde_params[$urandom_range(0, 11)]
                                                        : $urandom_range(0, 30);
                    end else if (fin == B_FIN_U) begin
                        r = $urandom_range(0, 7);
                        v = (r == 0) ? CP_ESC : (r == 1) ? 32'd0 : (r == 2) ? $urandom :
                            (r == 3) ? $urandom_range(128, 32'h10FFFF) : $urandom_range(0, 127);
                    end else begin
                        v = $urandom_range(0, 3);
                    end
                end else if (i == 1) begin
                    r = $urandom_range(0, 9);
                    v = (r == 0) ? 32'd0 : (r == 1) ? $urandom : $urandom_range(1, 8);
                end else begin
                    v = $urandom_range(0, 999);
                end
                queue_param(v);
            end
            if ($urandom_range(0, 11) == 0)
                queue_stray();
            queue_req(FUNC_BYTE, fin, 1'b0);
        end
    endtask

    always @(negedge i_clk) begin : drive_requests
        t_req r;
        if (!i_rst_n) begin
            req_if.valid     <= 1'b0;
            req_if.func      <= FUNC_BYTE;
            req_if.data_byte <= '0;
        end else if (req_if.valid && !req_fire) begin
            req_if.valid <= 1'b1;
        end else if (gap_left != 0) begin
            req_if.valid <= 1'b0;
            gap_left = gap_left - 1;
        end else if (pending_reqs.size() != 0) begin
            r = pending_reqs.pop_front();
            req_if.valid     <= 1'b1;
            req_if.func      <= r.func;
            req_if.data_byte <= r.data_byte;
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
                burst_left = burst_left - 1;
            end
        end else begin
            req_if.valid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin : drive_ready
        logic     rdy;
        t_rx_mode mode;
        if (!i_rst_n) begin
            key_if.ready <= 1'b0;
        end else begin
            mode = t_rx_mode'((rx_cycle / 150) % 4);
            case (mode)
                RX_ALWAYS: rdy = 1'b1;
                RX_RANDOM: rdy = ($urandom_range(0, 9) < 7);
                RX_RUNS: begin
                    if (stall_left > 0) begin
                        rdy = 1'b0;
                        stall_left = stall_left - 1;
                    end else begin
                        rdy = 1'b1;
                        if ($urandom_range(0, 5) == 0)
                            stall_left = $urandom_range(1, 12);
                    end
                end
                default: rdy = ((rx_cycle % 5) != 0);
            endcase
            key_if.ready <= rdy;
            rx_cycle = rx_cycle + 1;
        end
    end

    always @(posedge i_clk) begin : check_keys
        t_key want;
        req_fire <= req_if.valid && req_if.ready;
        if (i_rst_n) begin
            if (key_if.valid && key_if.ready) begin
                key_events++;
                if (key_if.key_special != K_CHAR)
                    special_keys++;
                if (expected_keys.size() == 0) begin
                    report_mismatch("unexpected key event", {27'd0, key_if.key_special}, '0);
                end else begin
                    want = expected_keys.pop_front();
                    if (key_if.key_special !== want.key_special)
                        report_mismatch("key_special", {27'd0, key_if.key_special},
                                        {27'd0, want.key_special});
                    if (key_if.char_code !== want.char_code)
                        report_mismatch("char_code", key_if.char_code, want.char_code);
                    if (key_if.modifiers !== want.modifiers)
                        report_mismatch("modifiers", {29'd0, key_if.modifiers},
                                        {29'd0, want.modifiers});
                end
            end
            if (req_if.valid && req_if.ready) begin
                accepted_reqs++;
                if (req_if.func == FUNC_TIMEOUT)
                    timeout_reqs++;
                decode_request(req_if.func, req_if.data_byte);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Run did not drain in time: %0d requests pending, %0d key events outstanding.",
                 pending_reqs.size(), expected_keys.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : main
        int kind;
        int n;
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.func      = FUNC_BYTE;
        req_if.data_byte = '0;
        key_if.ready     = 1'b0;

        // Directed requests: field extremes and the corner cases of each decoder phase.
        queue_req(FUNC_TIMEOUT, 8'hFF, 1'b1);
        queue_req(FUNC_BYTE, 8'h00, 1'b0);
        queue_req(FUNC_BYTE, B_CTRL_FIRST, 1'b0);
        queue_req(FUNC_BYTE, B_BS, 1'b0);
        queue_req(FUNC_BYTE, 8'hFF, 1'b0);
        queue_req(FUNC_BYTE, B_ESC, 1'b0);
        queue_req(FUNC_TIMEOUT, 8'h00, 1'b0);
        queue_req(FUNC_BYTE, B_ESC, 1'b0);
        queue_req(FUNC_BYTE, B_CTRL_LAST, 1'b0);
        queue_req(FUNC_BYTE, B_ESC, 1'b0);
        queue_req(FUNC_BYTE, B_ESC, 1'b0);
        queue_req(FUNC_BYTE, B_ESC, 1'b0);
        queue_req(FUNC_BYTE, B_SS3, 1'b0);
        queue_req(FUNC_BYTE, B_FIN_P, 1'b0);
        queue_req(FUNC_BYTE, B_ESC, 1'b0);
        queue_req(FUNC_BYTE, B_SS3, 1'b0);
        queue_req(FUNC_BYTE, B_FIN_UP, 1'b0);
        queue_req(FUNC_BYTE, B_ESC, 1'b0);
        queue_req(FUNC_BYTE, B_CSI, 1'b0);
        queue_number(32'd1);
        queue_req(FUNC_BYTE, B_SEMI, 1'b0);
        queue_number(32'd8);
        queue_req(FUNC_BYTE, B_FIN_UP, 1'b0);
        queue_req(FUNC_BYTE, B_ESC, 1'b0);
        queue_req(FUNC_BYTE, B_CSI, 1'b0);
        queue_number(32'd27);
        queue_req(FUNC_BYTE, B_FIN_U, 1'b0);

        while (stimulus_items < STIM_ITEMS) begin
            kind = $urandom_range(0, 19);
            if (kind < 4) begin
                queue_req(FUNC_BYTE, 8'($urandom_range(0, 255)), 1'b0);
            end else if (kind < 6) begin
                queue_req(FUNC_BYTE, 8'($urandom_range(B_CTRL_FIRST, B_CTRL_LAST)), 1'b0);
            end else if (kind < 8) begin
                queue_req(FUNC_BYTE, B_ESC, 1'b0);
                queue_req(FUNC_BYTE, 8'($urandom_range(0, 255)), 1'b0);
            end else if (kind == 8) begin
                queue_req(FUNC_BYTE, B_ESC, 1'b0);
                queue_req(FUNC_TIMEOUT, 8'($urandom_range(0, 255)), 1'b0);
            end else if (kind < 11) begin
                queue_req(FUNC_BYTE, B_ESC, 1'b0);
                queue_req(FUNC_BYTE, B_SS3, 1'b0);
                queue_req(FUNC_BYTE, ($urandom_range(0, 3) != 0)
                          ? 8'($urandom_range(B_FIN_P, B_FIN_S)) : 8'($urandom_range(0, 255)),
                          1'b0);
            end else if (kind < 18) begin
                queue_csi();
            end else if (kind == 18) begin
                queue_req(FUNC_TIMEOUT, 8'($urandom_range(0, 255)), 1'b1);
            end else begin
                queue_req(FUNC_BYTE, B_ESC, 1'b0);
                queue_req(FUNC_BYTE, B_CSI, 1'b0);
                n = $urandom_range(1, 3);
                repeat (n) queue_req(FUNC_BYTE, 8'($urandom_range(0, 255)), 1'b0);
            end
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_reqs.size() != 0 || req_if.valid)
            @(posedge i_clk);
        while (expected_keys.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Decoded %0d requests (%0d of them timeout ticks) into %0d key events,",
                 accepted_reqs, timeout_reqs, key_events);
        $display("%0d of which were special keys; %0d field mismatches seen.",
                 special_keys, mismatch_count);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
